FILE: sv/rtte_pkg.sv
package rtte_pkg;

    // ASCII characters that the parser looks for.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Character positions inside the fixed YYYY-MM-DDTHH:MM:SS layout.
    localparam logic [4:0] POS_DASH_A  = 5'd4;
    localparam logic [4:0] POS_DASH_B  = 5'd7;
    localparam logic [4:0] POS_T       = 5'd10;
    localparam logic [4:0] POS_COLON_A = 5'd13;
    localparam logic [4:0] POS_COLON_B = 5'd16;
    localparam logic [4:0] POS_YEAR_END  = 5'd3;
    localparam logic [4:0] POS_MONTH_END = 5'd6;
    localparam logic [4:0] POS_DAY_END   = 5'd9;
    localparam logic [4:0] POS_HOUR_END  = 5'd12;
    localparam logic [4:0] POS_MIN_END   = 5'd15;
    localparam logic [4:0] POS_LAST      = 5'd18;
    localparam logic [4:0] OFF_DIGITS    = 5'd2;

    // Multiplier operands of the calendar arithmetic.
    localparam logic signed [18:0] K_RECIP25   = 19'sd1311;   // x/25 as (x*1311)>>15
    localparam logic signed [18:0] K_NEG_ERA   = -19'sd400;
    localparam logic signed [18:0] K_MONTH_MUL = 19'sd153;
    localparam logic signed [18:0] K_RECIP5    = 19'sd26215;  // x/5 as (x*26215)>>17
    localparam logic signed [18:0] K_DAYS_YEAR = 19'sd365;
    localparam logic signed [18:0] K_DAYS_ERA  = 19'sd146097;
    localparam logic signed [18:0] K_SEC_HOUR  = 19'sd3600;
    localparam logic signed [18:0] K_SEC_MIN   = 19'sd60;
    localparam logic signed [18:0] K_SEC_DAY   = 19'sd86400;

    localparam logic [14:0] K_ERA_YEARS   = 15'd400;
    // Day of 1970-01-01 from the civil epoch plus one era, since the era is kept biased by one.
    localparam logic [47:0] K_EPOCH_SHIFT = 48'd865565;

    typedef enum logic [2:0] {
        PH_LAYOUT = 3'd0,
        PH_ZONE   = 3'd1,
        PH_FRAC   = 3'd2,
        PH_OFFH   = 3'd3,
        PH_OFFM   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        SQ_PARSE = 4'd0,
        SQ_ERA   = 4'd1,
        SQ_YOE   = 4'd2,
        SQ_C100  = 4'd3,
        SQ_NUM   = 4'd4,
        SQ_DOY   = 4'd5,
        SQ_DOE   = 4'd6,
        SQ_DAYS  = 4'd7,
        SQ_TOD1  = 4'd8,
        SQ_TOD2  = 4'd9,
        SQ_TOD3  = 4'd10,
        SQ_TOD4  = 4'd11,
        SQ_SEC   = 4'd12,
        SQ_EMIT  = 4'd13
    } t_seq;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  sec;
        logic        offset_negative;
        logic [6:0]  offset_hours;
        logic [6:0]  offset_minutes;
    } t_fields;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic               is_valid;
        logic signed [39:0] epoch_seconds;
    } t_out_word;

    function automatic logic [6:0] acc2(input logic [6:0] acc, input logic [3:0] dig);
        return 7'(11'(acc) * 11'd10 + 11'(dig));
    endfunction

endpackage

FILE: sv/rtte_ifs.sv
interface rtte_in_if;
    logic               valid;
    logic               ready;
    rtte_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtte_out_if;
    logic                valid;
    logic                ready;
    rtte_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/rtte_parse.sv
module rtte_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_clear,
    input  logic [7:0]        i_char,
    output rtte_pkg::t_fields o_fields,
    output logic              o_complete
);

    rtte_pkg::t_phase  r_phase, n_phase;
    logic [4:0]        r_idx, n_idx;
    rtte_pkg::t_fields r_f, n_f;
    logic              r_bad, n_bad;

    logic       w_digit;
    logic [3:0] w_dval;
    logic       w_has_sep;
    logic [7:0] w_sep;

    assign w_digit = (i_char >= rtte_pkg::CH_ZERO) && (i_char <= rtte_pkg::CH_NINE);
    assign w_dval  = i_char[3:0];

    always_comb begin
        w_has_sep = 1'b1;
        w_sep     = rtte_pkg::CH_DASH;
        priority if (r_idx == rtte_pkg::POS_DASH_A || r_idx == rtte_pkg::POS_DASH_B) begin
            w_sep = rtte_pkg::CH_DASH;
        end else if (r_idx == rtte_pkg::POS_T) begin
            w_sep = rtte_pkg::CH_T;
        end else if (r_idx == rtte_pkg::POS_COLON_A || r_idx == rtte_pkg::POS_COLON_B) begin
            w_sep = rtte_pkg::CH_COLON;
        end else begin
            w_has_sep = 1'b0;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_f     = r_f;
        n_bad   = r_bad;
        if (i_clear) begin
            n_phase = rtte_pkg::PH_LAYOUT;
            n_idx   = '0;
            n_f     = '0;
            n_bad   = 1'b0;
        end else if (i_take) begin
            unique case (r_phase)
                rtte_pkg::PH_LAYOUT: begin
                    if (w_has_sep) begin
                        if (i_char != w_sep) begin
                            n_bad = 1'b1;
                        end
                    end else if (!w_digit) begin
                        n_bad = 1'b1;
                    end else if (r_idx <= rtte_pkg::POS_YEAR_END) begin
                        n_f.year = 14'(18'(r_f.year) * 18'd10 + 18'(w_dval));
                    end else if (r_idx <= rtte_pkg::POS_MONTH_END) begin
                        n_f.month = rtte_pkg::acc2(r_f.month, w_dval);
                    end else if (r_idx <= rtte_pkg::POS_DAY_END) begin
                        n_f.day = rtte_pkg::acc2(r_f.day, w_dval);
                    end else if (r_idx <= rtte_pkg::POS_HOUR_END) begin
                        n_f.hour = rtte_pkg::acc2(r_f.hour, w_dval);
                    end else if (r_idx <= rtte_pkg::POS_MIN_END) begin
                        n_f.minute = rtte_pkg::acc2(r_f.minute, w_dval);
                    end else begin
                        n_f.sec = rtte_pkg::acc2(r_f.sec, w_dval);
                    end
                    if (r_idx >= rtte_pkg::POS_LAST) begin
                        n_phase = rtte_pkg::PH_ZONE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
                rtte_pkg::PH_ZONE: begin
                    if (i_char == rtte_pkg::CH_DOT) begin
                        n_phase = rtte_pkg::PH_FRAC;
                    end else if (i_char == rtte_pkg::CH_Z || i_char == rtte_pkg::CH_NUL) begin
                        n_phase = rtte_pkg::PH_DONE;
                    end else begin
                        // Anything other than a minus sign counts as a plus.
                        n_f.offset_negative = (i_char == rtte_pkg::CH_DASH);
                        n_phase             = rtte_pkg::PH_OFFH;
                        n_idx               = '0;
                    end
                end
                rtte_pkg::PH_FRAC: begin
                    if (i_char == rtte_pkg::CH_Z || i_char == rtte_pkg::CH_NUL) begin
                        n_phase = rtte_pkg::PH_DONE;
                    end else if (i_char == rtte_pkg::CH_PLUS || i_char == rtte_pkg::CH_DASH) begin
                        n_f.offset_negative = (i_char == rtte_pkg::CH_DASH);
                        n_phase             = rtte_pkg::PH_OFFH;
                        n_idx               = '0;
                    end
                end
                rtte_pkg::PH_OFFH: begin
                    if (w_digit && r_idx < rtte_pkg::OFF_DIGITS) begin
                        n_f.offset_hours = rtte_pkg::acc2(r_f.offset_hours, w_dval);
                        n_idx            = r_idx + 5'd1;
                    end else if (i_char == rtte_pkg::CH_COLON && r_idx != '0) begin
                        n_phase = rtte_pkg::PH_OFFM;
                        n_idx   = '0;
                    end else begin
                        n_phase = rtte_pkg::PH_DONE;
                    end
                end
                rtte_pkg::PH_OFFM: begin
                    if (w_digit && r_idx < rtte_pkg::OFF_DIGITS) begin
                        n_f.offset_minutes = rtte_pkg::acc2(r_f.offset_minutes, w_dval);
                        n_idx              = r_idx + 5'd1;
                    end else begin
                        n_phase = rtte_pkg::PH_DONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rtte_pkg::PH_LAYOUT;
            r_idx   <= '0;
            r_f     <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_f     <= n_f;
            r_bad   <= n_bad;
        end
    end

    assign o_fields   = r_f;
    // Taken together with the character being accepted.
    assign o_complete = (n_phase != rtte_pkg::PH_LAYOUT) && !n_bad;

endmodule

FILE: sv/rtte_mac.sv
module rtte_mac (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [24:0] i_a,
    input  logic signed [18:0] i_b,
    input  logic signed [47:0] i_c,
    output logic signed [47:0] o_acc
);

    logic signed [43:0] w_prod;
    logic signed [47:0] r_acc, n_acc;

    assign w_prod = i_a * i_b;

    always_comb begin
        n_acc = r_acc;
        if (i_en) begin
            n_acc = 48'(w_prod) + i_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

FILE: sv/rfc3339_timestamp_to_epoch_unit.sv
// Input: characters that are not the last one of a string are taken at one per cycle.
// After the last character of a well-formed string the sequencer runs SQ_ERA to SQ_SEC,
// then SQ_EMIT loads the output register; a malformed or short string skips to SQ_EMIT.
// Throughput: the input is held off from the last character until the result is loaded,
// since the single multiply-add unit steps through 12 operations of the date arithmetic.
// Reset: synchronous, active low; clears the parser, the sequencer and the output valid.
module rfc3339_timestamp_to_epoch_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtte_in_if.sink    i_in,
    rtte_out_if.source o_out
);

    // Parser: collects the date, time and offset fields one character at a time.
    rtte_pkg::t_fields w_f;
    logic              w_complete;
    logic              w_take;
    logic              w_clear;

    rtte_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_clear    (w_clear),
        .i_char     (i_in.data.char_code),
        .o_fields   (w_f),
        .o_complete (w_complete)
    );

    // Shared multiply-add unit; every step of the conversion goes through it.
    logic               w_en;
    logic signed [24:0] w_a;
    logic signed [18:0] w_b;
    logic signed [47:0] w_c;
    logic signed [47:0] w_acc;

    rtte_mac u_mac (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .i_c   (w_c),
        .o_acc (w_acc)
    );

    rtte_pkg::t_seq      r_state, n_state;
    logic [5:0]          r_q1, n_q1;       // era + 1
    logic [8:0]          r_yoe, n_yoe;     // year of era
    logic [1:0]          r_c100, n_c100;   // year of era / 100
    logic signed [23:0]  r_days, n_days;   // days since 1970-01-01
    logic                r_ok, n_ok;
    logic                r_out_valid, n_out_valid;
    rtte_pkg::t_out_word r_out_word, n_out_word;

    // The civil year starts in March, so January and February belong to the year before.
    // The year is biased by one era so that the era quotient is never negative.
    logic        w_lowm;
    logic [14:0] w_v;
    logic [6:0]  w_mm;
    logic [11:0] w_doy5;

    assign w_lowm = (w_f.month <= 7'd2);
    assign w_v    = 15'(w_f.year) + rtte_pkg::K_ERA_YEARS - 15'(w_lowm);
    assign w_mm   = w_lowm ? (w_f.month + 7'd9) : (w_f.month - 7'd3);
    assign w_doy5 = w_acc[28:17];

    assign w_take     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == rtte_pkg::SQ_PARSE);

    always_comb begin
        n_state     = r_state;
        n_q1        = r_q1;
        n_yoe       = r_yoe;
        n_c100      = r_c100;
        n_days      = r_days;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        w_en        = 1'b0;
        w_a         = '0;
        w_b         = '0;
        w_c         = '0;
        w_clear     = 1'b0;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rtte_pkg::SQ_PARSE: begin
                if (w_take && i_in.data.last_char) begin
                    n_ok    = w_complete;
                    n_state = w_complete ? rtte_pkg::SQ_ERA : rtte_pkg::SQ_EMIT;
                end
            end
            rtte_pkg::SQ_ERA: begin
                // floor(v / 400) as floor((v >> 4) / 25).
                w_en    = 1'b1;
                w_a     = $signed({14'd0, w_v[14:4]});
                w_b     = rtte_pkg::K_RECIP25;
                n_state = rtte_pkg::SQ_YOE;
            end
            rtte_pkg::SQ_YOE: begin
                n_q1    = w_acc[20:15];
                w_en    = 1'b1;
                w_a     = $signed({19'd0, w_acc[20:15]});
                w_b     = rtte_pkg::K_NEG_ERA;
                w_c     = $signed(48'(w_v));
                n_state = rtte_pkg::SQ_C100;
            end
            rtte_pkg::SQ_C100: begin
                n_yoe   = w_acc[8:0];
                w_en    = 1'b1;
                w_a     = $signed({18'd0, w_acc[8:2]});
                w_b     = rtte_pkg::K_RECIP25;
                n_state = rtte_pkg::SQ_NUM;
            end
            rtte_pkg::SQ_NUM: begin
                n_c100  = w_acc[16:15];
                w_en    = 1'b1;
                w_a     = $signed({18'd0, w_mm});
                w_b     = rtte_pkg::K_MONTH_MUL;
                w_c     = 48'sd2;
                n_state = rtte_pkg::SQ_DOY;
            end
            rtte_pkg::SQ_DOY: begin
                w_en    = 1'b1;
                w_a     = $signed({10'd0, w_acc[14:0]});
                w_b     = rtte_pkg::K_RECIP5;
                n_state = rtte_pkg::SQ_DOE;
            end
            rtte_pkg::SQ_DOE: begin
                // Day of era, with the epoch offset already folded in.
                w_en    = 1'b1;
                w_a     = $signed({16'd0, r_yoe});
                w_b     = rtte_pkg::K_DAYS_YEAR;
                w_c     = $signed(48'(r_yoe[8:2]) - 48'(r_c100) + 48'(w_doy5)
                                  + 48'(w_f.day) - 48'd1 - rtte_pkg::K_EPOCH_SHIFT);
                n_state = rtte_pkg::SQ_DAYS;
            end
            rtte_pkg::SQ_DAYS: begin
                w_en    = 1'b1;
                w_a     = $signed({19'd0, r_q1});
                w_b     = rtte_pkg::K_DAYS_ERA;
                w_c     = w_acc;
                n_state = rtte_pkg::SQ_TOD1;
            end
            rtte_pkg::SQ_TOD1: begin
                n_days  = w_acc[23:0];
                w_en    = 1'b1;
                w_a     = $signed({18'd0, w_f.hour});
                w_b     = rtte_pkg::K_SEC_HOUR;
                w_c     = $signed(48'(w_f.sec));
                n_state = rtte_pkg::SQ_TOD2;
            end
            rtte_pkg::SQ_TOD2: begin
                w_en    = 1'b1;
                w_a     = $signed({18'd0, w_f.minute});
                w_b     = rtte_pkg::K_SEC_MIN;
                w_c     = w_acc;
                n_state = rtte_pkg::SQ_TOD3;
            end
            rtte_pkg::SQ_TOD3: begin
                // A negative offset means local time is behind UTC, so it is added.
                w_en    = 1'b1;
                w_a     = $signed({18'd0, w_f.offset_hours});
                w_b     = w_f.offset_negative ? rtte_pkg::K_SEC_HOUR : -rtte_pkg::K_SEC_HOUR;
                w_c     = w_acc;
                n_state = rtte_pkg::SQ_TOD4;
            end
            rtte_pkg::SQ_TOD4: begin
                w_en    = 1'b1;
                w_a     = $signed({18'd0, w_f.offset_minutes});
                w_b     = w_f.offset_negative ? rtte_pkg::K_SEC_MIN : -rtte_pkg::K_SEC_MIN;
                w_c     = w_acc;
                n_state = rtte_pkg::SQ_SEC;
            end
            rtte_pkg::SQ_SEC: begin
                w_en    = 1'b1;
                w_a     = $signed({r_days[23], r_days});
                w_b     = rtte_pkg::K_SEC_DAY;
                w_c     = w_acc;
                n_state = rtte_pkg::SQ_EMIT;
            end
            rtte_pkg::SQ_EMIT: begin
                // Load the output register once it is free, then start the next string.
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid              = 1'b1;
                    n_out_word.is_valid      = r_ok;
                    n_out_word.epoch_seconds = r_ok ? w_acc[39:0] : '0;
                    w_clear                  = 1'b1;
                    n_state                  = rtte_pkg::SQ_PARSE;
                end
            end
            default: begin
                n_state = rtte_pkg::SQ_PARSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rtte_pkg::SQ_PARSE;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1       <= n_q1;
        r_yoe      <= n_yoe;
        r_c100     <= n_c100;
        r_days     <= n_days;
        r_out_word <= n_out_word;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

endmodule

FILE: sv/rtte_chk.sv
module rtte_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_is_valid,
    input logic [39:0] i_out_epoch
);

    // A waiting word keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_is_valid) && $stable(i_out_epoch)))
        else $error("output word changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_is_valid) |-> (i_out_epoch == 40'd0))
        else $error("invalid result carries nonzero seconds");

    a_stream_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_in_last) |=> i_in_ready)
        else $error("input stalled in the middle of a string");

    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> !i_in_ready)
        else $error("input taken while the conversion runs");

endmodule

bind rfc3339_timestamp_to_epoch_unit rtte_chk u_rtte_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_last      (i_in.data.last_char),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_is_valid (o_out.data.is_valid),
    .i_out_epoch    (o_out.data.epoch_seconds)
);
